### design/tro_pkg.sv
// ----------------------------------------------------------------------------
// tro_pkg: shared constants for the triangle/rectangle overlap test
// Coordinate format defaults used by the top level.
// ----------------------------------------------------------------------------
package tro_pkg;
    localparam int COORD_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 16;
endpackage

### design/triangle_rect_overlap_test.sv
// ----------------------------------------------------------------------------
// triangle_rect_overlap_test: 2D triangle vs axis-aligned rectangle overlap
// Fully pipelined exact fixed point test, one beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  i_valid/o_ready carries one triangle and one rectangle
//   per beat; output channel o_valid/i_ready carries one overlap flag.
//   Pipeline of five register stages: points, differences, products, cross
//   terms, range compares with final reduction. Throughput is one beat per
//   cycle while the output is not stalled (one multiplier per product, all
//   in parallel).
//   The whole pipeline advances when the output stage is empty or taken,
//   so a stalled receiver holds every stage; nothing is lost or repeated.
//   o_ready is high whenever the last stage can move.
//   Reset clears all valid bits; payload registers are not reset.
//   FRACTION_BITS only names the scale and does not change the result.
//   Products are exact: coordinate differences are COORD_BITS+2 bits and
//   cross terms 2*COORD_BITS+6 bits, so no compare ever wraps.
// ----------------------------------------------------------------------------
module triangle_rect_overlap_test #(
    parameter int COORD_BITS    = tro_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = tro_pkg::FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_tri_u0,
    input  logic signed [COORD_BITS-1:0] i_tri_v0,
    input  logic signed [COORD_BITS-1:0] i_tri_u1,
    input  logic signed [COORD_BITS-1:0] i_tri_v1,
    input  logic signed [COORD_BITS-1:0] i_tri_u2,
    input  logic signed [COORD_BITS-1:0] i_tri_v2,
    input  logic signed [COORD_BITS-1:0] i_rect_x,
    input  logic signed [COORD_BITS-1:0] i_rect_y,
    input  logic        [COORD_BITS-2:0] i_rect_width,
    input  logic        [COORD_BITS-2:0] i_rect_height,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_overlaps
);
    localparam int DW = COORD_BITS + 2;       // differences
    localparam int PW = 2 * DW;               // products
    localparam int XW = PW + 2;               // cross terms and sums
    localparam int NS = 5;
    localparam int NT = 12 + 4;               // 12 segment tests, 4 corners

    logic [NS-1:0] r_vld;
    logic          adv;
    logic          unused_frac;

    assign unused_frac = (FRACTION_BITS > 0);
    assign adv     = !r_vld[NS-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // ---------------- stage 1: points and vertex-in-rectangle test ----------------
    logic signed [DW-1:0] px [7];   // 3 vertices then 4 corners
    logic signed [DW-1:0] py [7];
    logic                 n_vhit;
    logic signed [DW-1:0] r_px [7];
    logic signed [DW-1:0] r_py [7];
    logic                 r_vhit1;

    always_comb begin
        px[0] = DW'(i_tri_u0); py[0] = DW'(i_tri_v0);
        px[1] = DW'(i_tri_u1); py[1] = DW'(i_tri_v1);
        px[2] = DW'(i_tri_u2); py[2] = DW'(i_tri_v2);
        px[3] = DW'(i_rect_x);
        py[3] = DW'(i_rect_y);
        px[4] = DW'(i_rect_x) + DW'({1'b0, i_rect_width});
        py[4] = py[3];
        px[5] = px[4];
        py[5] = DW'(i_rect_y) + DW'({1'b0, i_rect_height});
        px[6] = px[3];
        py[6] = py[5];
        n_vhit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (px[k] >= px[3] && px[k] <= px[4] && py[k] >= py[3] && py[k] <= py[5])
                n_vhit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px    <= px;
            r_py    <= py;
            r_vhit1 <= n_vhit;
        end
    end

    // operand terms: each test gives den=a*b-c*d, na=e*f-g*h, nb=...
    // tests 0..11 segments (rect edge r, tri edge t), 12..15 corners
    logic signed [DW-1:0] op [NT][3][4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int t = 0; t < 3; t++) begin
                int a1, a2, b1, b2;
                logic signed [DW-1:0] dx34, dy34, dx12, dy12, ox, oy;
                a1 = 3 + r;
                a2 = 3 + ((r + 1) % 4);
                b1 = t;
                b2 = (t + 1) % 3;
                dx34 = r_px[b2] - r_px[b1];
                dy34 = r_py[b2] - r_py[b1];
                dx12 = r_px[a2] - r_px[a1];
                dy12 = r_py[a2] - r_py[a1];
                ox   = r_px[a1] - r_px[b1];
                oy   = r_py[a1] - r_py[b1];
                op[r*3+t][0] = '{dy34, dx12, dx34, dy12};
                op[r*3+t][1] = '{dx34, oy, dy34, ox};
                op[r*3+t][2] = '{dx12, oy, dy12, ox};
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic signed [DW-1:0] ca, cb, cc, cd, ce, cf;
            ca = r_px[0] - r_px[2];
            cb = r_px[1] - r_px[2];
            cc = r_px[2] - r_px[3+c];
            cd = r_py[0] - r_py[2];
            ce = r_py[1] - r_py[2];
            cf = r_py[2] - r_py[3+c];
            op[12+c][0] = '{ca, ce, cb, cd};
            op[12+c][1] = '{cb, cf, cc, ce};
            // nb = -(a*f - c*d) = c*d - a*f
            op[12+c][2] = '{cc, cd, ca, cf};
        end
    end

    // ---------------- stage 2: operands registered ----------------
    logic signed [DW-1:0] r_op [NT][3][4];
    logic                 r_vhit2;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_op    <= op;
            r_vhit2 <= r_vhit1;
        end
    end

    // ---------------- stage 3: products ----------------
    logic signed [PW-1:0] r_pr [NT][3][2];
    logic                 r_vhit3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int n = 0; n < NT; n++) begin
                for (int q = 0; q < 3; q++) begin
                    r_pr[n][q][0] <= PW'(r_op[n][q][0]) * PW'(r_op[n][q][1]);
                    r_pr[n][q][1] <= PW'(r_op[n][q][2]) * PW'(r_op[n][q][3]);
                end
            end
            r_vhit3 <= r_vhit2;
        end
    end

    // ---------------- stage 4: cross terms ----------------
    logic signed [XW-1:0] r_cr [NT][3];
    logic                 r_vhit4;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int n = 0; n < NT; n++) begin
                for (int q = 0; q < 3; q++) begin
                    r_cr[n][q] <= XW'(r_pr[n][q][0]) - XW'(r_pr[n][q][1]);
                end
            end
            r_vhit4 <= r_vhit3;
        end
    end

    // ---------------- stage 5: range compares and reduction ----------------
    function automatic logic in_unit(input logic signed [XW-1:0] n,
                                     input logic signed [XW-1:0] d);
        logic r;
        r = 1'b0;
        if (d > 0)      r = (n >= 0) && (n <= d);
        else if (d < 0) r = (n <= 0) && (n >= d);
        return r;
    endfunction

    logic n_hit;
    logic r_hit;

    always_comb begin
        logic signed [XW-1:0] nc;
        n_hit = r_vhit4;
        for (int n = 0; n < 12; n++) begin
            if (in_unit(r_cr[n][1], r_cr[n][0]) && in_unit(r_cr[n][2], r_cr[n][0]))
                n_hit = 1'b1;
        end
        for (int n = 12; n < NT; n++) begin
            nc = r_cr[n][0] - r_cr[n][1] - r_cr[n][2];
            if (in_unit(r_cr[n][1], r_cr[n][0]) && in_unit(r_cr[n][2], r_cr[n][0])
                && in_unit(nc, r_cr[n][0]))
                n_hit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit <= n_hit;
        end
    end

    assign o_overlaps = r_hit;
endmodule

### design/tro_checker.sv
// ----------------------------------------------------------------------------
// tro_checker: port-level checks for triangle_rect_overlap_test
// Watches the handshakes and the pipeline behavior on the ports.
// ----------------------------------------------------------------------------
module tro_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_overlaps
);
    // output beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_overlaps))
        else $error("output beat changed while stalled");

    // ready follows the output side only
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input not ready while output free");

    // an empty output stage never refuses input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("stalled with empty output");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
endmodule

bind triangle_rect_overlap_test tro_checker u_tro_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_overlaps(o_overlaps)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for triangle_rect_overlap_test
// Streams triangle/rectangle pairs through the valid/ready input channel and
// checks every overlap flag against an exact integer prediction made at the
// time each beat is accepted. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int CB        = tro_pkg::COORD_BITS_DEF;
    localparam int N_RANDOM  = 1425;
    localparam int QUIET_TAIL = 120;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [CB-1:0] u0, v0, u1, v1, u2, v2;
        logic signed [CB-1:0] rx, ry;
        logic        [CB-2:0] rw, rh;
        logic                 drain;
    } t_shape_pair;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_overlaps;
    t_shape_pair cur = '0;

    t_shape_pair pend_q[$];
    bit          overlap_q[$];
    int          gap_cnt   = 0;
    int          stall_cnt = 0;
    int          cycles    = 0;
    bit          failed    = 0;

    always #1 i_clk = ~i_clk;

    triangle_rect_overlap_test dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_tri_u0     (cur.u0),
        .i_tri_v0     (cur.v0),
        .i_tri_u1     (cur.u1),
        .i_tri_v1     (cur.v1),
        .i_tri_u2     (cur.u2),
        .i_tri_v2     (cur.v2),
        .i_rect_x     (cur.rx),
        .i_rect_y     (cur.ry),
        .i_rect_width (cur.rw),
        .i_rect_height(cur.rh),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_overlaps   (o_overlaps)
    );

    // n/d within [0,1], zero denominator never passes
    function automatic bit ratio_in_unit(longint n, longint d);
        if (d == 0) return 0;
        if (d > 0) return n >= 0 && d - n >= 0;
        return n <= 0 && n - d >= 0;
    endfunction

    function automatic bit corner_inside(longint tu[3], longint tv[3], longint ex, longint ey);
        longint a, b, c, d, e, f, den, na, nb, nc;
        a = tu[0] - tu[2]; b = tu[1] - tu[2]; c = tu[2] - ex;
        d = tv[0] - tv[2]; e = tv[1] - tv[2]; f = tv[2] - ey;
        den = a * e - b * d;
        na  = b * f - c * e;
        nb  = -(a * f - c * d);
        nc  = den - na - nb;
        return ratio_in_unit(na, den) && ratio_in_unit(nb, den) && ratio_in_unit(nc, den);
    endfunction

    function automatic bit segments_cross(longint p1x, longint p1y, longint p2x, longint p2y,
                                          longint p3x, longint p3y, longint p4x, longint p4y);
        longint dx34, dy34, dx12, dy12, ox, oy, den;
        dx34 = p4x - p3x; dy34 = p4y - p3y;
        dx12 = p2x - p1x; dy12 = p2y - p1y;
        ox = p1x - p3x;   oy = p1y - p3y;
        den = dy34 * dx12 - dx34 * dy12;
        return ratio_in_unit(dx34 * oy - dy34 * ox, den) &&
               ratio_in_unit(dx12 * oy - dy12 * ox, den);
    endfunction

    function automatic bit predict_overlap(t_shape_pair s);
        longint tu[3], tv[3], cx[4], cy[4];
        int     j;
        bit     hit;
        tu[0] = s.u0; tu[1] = s.u1; tu[2] = s.u2;
        tv[0] = s.v0; tv[1] = s.v1; tv[2] = s.v2;
        // corners in order: lower left, lower right, upper right, upper left
        cx[0] = s.rx; cx[3] = s.rx; cx[1] = longint'(s.rx) + longint'(s.rw); cx[2] = cx[1];
        cy[0] = s.ry; cy[1] = s.ry; cy[2] = longint'(s.ry) + longint'(s.rh); cy[3] = cy[2];
        hit = 0;
        for (int i = 0; i < 3; i++)
            if (tu[i] >= cx[0] && tu[i] <= cx[1] && tv[i] >= cy[0] && tv[i] <= cy[2]) hit = 1;
        for (int k = 0; k < 4; k++)
            if (corner_inside(tu, tv, cx[k], cy[k])) hit = 1;
        for (int k = 0; k < 4; k++)
            for (int i = 0; i < 3; i++) begin
                j = (i == 2) ? 0 : i + 1;
                if (segments_cross(cx[k], cy[k], cx[(k + 1) % 4], cy[(k + 1) % 4],
                                   tu[i], tv[i], tu[j], tv[j])) hit = 1;
            end
        return hit;
    endfunction

    function automatic t_shape_pair make_pair(longint u0, longint v0, longint u1, longint v1,
                                              longint u2, longint v2, longint rx, longint ry,
                                              longint rw, longint rh);
        t_shape_pair s;
        s.u0 = CB'(u0); s.v0 = CB'(v0); s.u1 = CB'(u1); s.v1 = CB'(v1);
        s.u2 = CB'(u2); s.v2 = CB'(v2);
        s.rx = CB'(rx); s.ry = CB'(ry);
        s.rw = (CB-1)'(rw); s.rh = (CB-1)'(rh); s.drain = 1'b0;
        return s;
    endfunction

    // coordinate on a coarse grid so shared bounds and touching cases occur
    function automatic longint grid_coord(int span, int step);
        return (longint'($urandom_range(0, 2 * span)) - span) * step;
    endfunction

    function automatic t_shape_pair random_pair();
        t_shape_pair s;
        int          mode, step, span;
        longint      t;
        mode = $urandom_range(0, 9);
        step = 1 << $urandom_range(0, 16);
        span = $urandom_range(2, 40);
        if (mode < 2) begin
            // full range, every bit of every field
            s.u0 = CB'($urandom); s.v0 = CB'($urandom);
            s.u1 = CB'($urandom); s.v1 = CB'($urandom);
            s.u2 = CB'($urandom); s.v2 = CB'($urandom);
            s.rx = CB'($urandom); s.ry = CB'($urandom);
            s.rw = (CB-1)'($urandom); s.rh = (CB-1)'($urandom);
        end else begin
            s = make_pair(grid_coord(span, step), grid_coord(span, step),
                          grid_coord(span, step), grid_coord(span, step),
                          grid_coord(span, step), grid_coord(span, step),
                          grid_coord(span, step), grid_coord(span, step),
                          longint'($urandom_range(0, span)) * step,
                          longint'($urandom_range(0, span)) * step);
            if (mode == 2) begin
                // collinear triangle: third vertex on the line through the first two
                t = longint'($urandom_range(0, 4)) - 2;
                s.u2 = CB'(s.u0 + t * (s.u1 - s.u0));
                s.v2 = CB'(s.v0 + t * (s.v1 - s.v0));
            end else if (mode == 3) begin
                // triangle edge parallel to a rectangle side
                if ($urandom_range(0, 1)) s.v1 = s.v0; else s.u1 = s.u0;
            end else if (mode == 4) begin
                s.u1 = s.u0; s.v1 = s.v0;
            end
        end
        s.drain = 1'b0;
        return s;
    endfunction

    // driver: one nonblocking update per signal per edge
    always @(posedge i_clk) begin
        logic        nxt_valid;
        t_shape_pair nxt;
        int          nxt_gap;
        bit          quiet;
        nxt_valid = i_valid;
        nxt       = cur;
        nxt_gap   = gap_cnt;
        quiet     = pend_q.size() < QUIET_TAIL;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                overlap_q.push_back(predict_overlap(cur));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_cnt > 0) begin
                    nxt_gap = gap_cnt - 1;
                end else if (!quiet && $urandom_range(0, 15) == 0) begin
                    nxt_gap = $urandom_range(1, 14);
                end else if (pend_q.size() > 0 &&
                             !(pend_q[0].drain && overlap_q.size() > 0)) begin
                    nxt       = pend_q.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        i_valid <= nxt_valid;
        cur     <= nxt;
        gap_cnt <= nxt_gap;
    end

    // monitor and receiver-side stalls
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (overlap_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none actual %b",
                             $time, o_overlaps);
                    failed = 1;
                end else begin
                    want = overlap_q.pop_front();
                    if (o_overlaps !== want) begin
                        $display("%0t: overlaps mismatch, expected %b actual %b",
                                 $time, want, o_overlaps);
                        failed = 1;
                    end
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                i_ready   <= 1'b0;
            end else if (pend_q.size() >= QUIET_TAIL && $urandom_range(0, 15) == 0) begin
                stall_cnt <= $urandom_range(1, 14);
                i_ready   <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_shape_pair s;
        longint      mx, mn, wm, q;
        mx = (longint'(1) << (CB - 1)) - 1;
        mn = -(longint'(1) << (CB - 1));
        wm = mx;
        q  = 10 << 16;
        // vertex on a rectangle corner, and just outside it
        pend_q.push_back(make_pair(0, 0, -q, -q, -q, 0, 0, 0, q, q));
        pend_q.push_back(make_pair(-1, -1, -q, -q, -q, 0, 0, 0, q, q));
        pend_q.push_back(make_pair(q, q, 2 * q, 2 * q, 2 * q, q, 0, 0, q, q));
        // rectangle inside a large triangle
        pend_q.push_back(make_pair(-8 * q, -8 * q, 8 * q, -8 * q, 0, 8 * q, 0, 0, q, q));
        // corner on a triangle edge
        pend_q.push_back(make_pair(-5 * q, 0, 5 * q, 0, 0, -5 * q, 0, 0, q, q));
        // thin triangle passing through, no vertex or corner inside
        pend_q.push_back(make_pair(-q, q / 2, 2 * q, q / 2, 2 * q, q / 2 + 1, 0, 0, q, q));
        // collinear overlap along a side only
        pend_q.push_back(make_pair(-q, 0, 2 * q, 0, 3 * q, 0, 0, 0, q, q));
        // degenerate triangles: collinear across the box, and a single point outside
        pend_q.push_back(make_pair(-5 * q, q / 2, 5 * q, q / 2, 6 * q, q / 2, 0, 0, q, q));
        pend_q.push_back(make_pair(3 * q, 3 * q, 3 * q, 3 * q, 3 * q, 3 * q, 0, 0, q, q));
        // zero size rectangle, on and off a triangle
        pend_q.push_back(make_pair(-q, -q, q, -q, 0, q, 0, 0, 0, 0));
        pend_q.push_back(make_pair(-q, -q, q, -q, 0, q, 5 * q, 5 * q, 0, 0));
        // extremes of every field
        pend_q.push_back(make_pair(mx, mx, mx, mx, mx, mx, mn, mn, wm, wm));
        pend_q.push_back(make_pair(mn, mn, mx, mn, mn, mx, mx, mx, wm, wm));
        pend_q.push_back(make_pair(mn, mn, mn, mn, mn, mn, mx, mx, 0, 0));
        pend_q.push_back(make_pair(mn, mx, mx, mn, mx, mx, mn, mn, wm, 0));
        pend_q.push_back(make_pair(mx, mn, mn, mx, mn, mn, 0, 0, 0, wm));
        pend_q.push_back(make_pair(mn, mn, mx, mx, mn, mx, mx, mn, wm, wm));
        for (int n = 0; n < N_RANDOM; n++) begin
            s = random_pair();
            // let the pipeline empty completely now and then
            if (n % 400 == 200) s.drain = 1'b1;
            pend_q.push_back(s);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pend_q.size() > 0 || i_valid || overlap_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed && overlap_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

### triangle_rect_overlap_test.f
design/tro_pkg.sv
design/triangle_rect_overlap_test.sv
design/tro_checker.sv
tb/sv/tb_top.sv
